@@ hw/rtl/mhtq_pkg.sv @@
// Timer queue package: field widths, operation and status codes, heap entry type,
// controller state and command/status structs. No dependencies.
package mhtq_pkg;

	localparam int unsigned HEAP_CAPACITY_DEF = 64;
	localparam int unsigned ID_SPACE_DEF      = 1024;

	localparam int unsigned OP_W   = 3;
	localparam int unsigned ID_W   = 10;
	localparam int unsigned TMO_W  = 31;
	localparam int unsigned TIME_W = 48;
	localparam int unsigned STAT_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 3'd0,
		OP_ADJUST = 3'd1,
		OP_FIRE   = 3'd2,
		OP_EXPIRE = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_UNKNOWN = 2'd2;

	typedef struct packed {
		logic [TIME_W-1:0] expiry;
		logic [ID_W-1:0]   owner;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LOOK1, S_LOOK2, S_LOOK3,
		S_DN1, S_DN2, S_DN3, S_DNCMP,
		S_UP, S_UPCMP, S_FIN,
		S_CHKN, S_RDLAST, S_LAST2, S_POST,
		S_EXPCHK, S_EXPEMIT, S_EMIT
	} state_t;

	typedef enum logic [2:0] {RD_SLOT, RD_C1, RD_C2, RD_PAR, RD_LAST} rd_sel_t;
	typedef enum logic [1:0] {I_HOLD, I_SLOT, I_COUNT, I_ZERO} i_sel_t;
	typedef enum logic [1:0] {N_HOLD, N_CNT, N_INC, N_DEC} n_sel_t;
	typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR} cnt_op_t;

	typedef struct packed {
		logic              ld_in;
		rd_sel_t           rd_sel;
		logic              ld_e_in;
		logic              ld_e_rd;
		i_sel_t            i_sel;
		n_sel_t            n_sel;
		cnt_op_t           cnt_op;
		logic              clr_moved;
		logic              ld_ch1;
		logic              ld_ch2;
		logic              mv_ch;
		logic              mv_par;
		logic              wr_e;
		logic              res_ld;
		logic [STAT_W-1:0] res_status;
		logic              res_fv;
		logic              fid_root;
		logic              out_ld;
		logic              out_last;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic known;
		logic in_range;
		logic full;
		logic c1_ok;
		logic c2_ok;
		logic i_zero;
		logic e_lt_ch;
		logic par_lt_e;
		logic root_due;
		logic i_lt_n;
		logic moved;
		logic out_free;
	} sts_t;

endpackage

@@ hw/rtl/mhtq_ctrl.sv @@
// Timer queue controller: sequences lookup, sift down/up, pop and result issue.
// Depends on mhtq_pkg; drives mhtq_dp through cmd_t, reads sts_t.
module mhtq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mhtq_pkg::sts_t sts,
	output mhtq_pkg::cmd_t cmd
);
	import mhtq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_LOOK1;
			end
			S_LOOK1: state_d = S_LOOK2;
			S_LOOK2: state_d = S_LOOK3;
			S_LOOK3: begin
				case (sts.op)
					OP_ADD: begin
						if (sts.known) state_d = S_DN1;
						else if (!sts.in_range || sts.full) state_d = S_EMIT;
						else state_d = S_DN1;
					end
					OP_ADJUST: begin
						if (sts.known) state_d = S_DN1;
						else state_d = S_EMIT;
					end
					OP_FIRE: begin
						if (sts.known) state_d = S_CHKN;
						else state_d = S_EMIT;
					end
					OP_EXPIRE: state_d = S_EXPCHK;
					default:   state_d = S_EMIT;
				endcase
			end
			S_EXPCHK: state_d = sts.root_due ? S_CHKN : S_EMIT;
			S_CHKN:   state_d = sts.i_lt_n ? S_RDLAST : S_POST;
			S_RDLAST: state_d = S_LAST2;
			S_LAST2:  state_d = S_DN1;
			S_DN1: begin
				if (sts.c1_ok) state_d = S_DN2;
				else state_d = sts.moved ? S_FIN : S_UP;
			end
			S_DN2: state_d = sts.c2_ok ? S_DN3 : S_DNCMP;
			S_DN3: state_d = S_DNCMP;
			S_DNCMP: begin
				if (sts.e_lt_ch) state_d = sts.moved ? S_FIN : S_UP;
				else state_d = S_DN1;
			end
			S_UP:    state_d = sts.i_zero ? S_FIN : S_UPCMP;
			S_UPCMP: state_d = sts.par_lt_e ? S_FIN : S_UP;
			S_FIN:   state_d = S_POST;
			S_POST:  state_d = (sts.op == OP_EXPIRE) ? S_EXPEMIT : S_EMIT;
			S_EXPEMIT: begin
				if (sts.out_free) state_d = sts.root_due ? S_EXPCHK : S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_SLOT;
		cmd.i_sel = I_HOLD;
		cmd.n_sel = N_HOLD;
		cmd.cnt_op = CNT_HOLD;
		cmd.res_status = STAT_OK;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.ld_in = in_valid;
			end
			S_LOOK2: cmd.rd_sel = RD_SLOT;
			S_LOOK3: begin
				cmd.res_ld = 1'b1;
				case (sts.op)
					OP_ADD: begin
						if (sts.known) begin
							cmd.ld_e_in = 1'b1;
							cmd.i_sel = I_SLOT;
							cmd.n_sel = N_CNT;
							cmd.clr_moved = 1'b1;
						end else if (!sts.in_range) begin
							cmd.res_status = STAT_UNKNOWN;
						end else if (sts.full) begin
							cmd.res_status = STAT_FULL;
						end else begin
							cmd.ld_e_in = 1'b1;
							cmd.i_sel = I_COUNT;
							cmd.n_sel = N_INC;
							cmd.cnt_op = CNT_INC;
							cmd.clr_moved = 1'b1;
						end
					end
					OP_ADJUST: begin
						if (sts.known) begin
							cmd.ld_e_in = 1'b1;
							cmd.i_sel = I_SLOT;
							cmd.n_sel = N_CNT;
							cmd.clr_moved = 1'b1;
						end else begin
							cmd.res_status = STAT_UNKNOWN;
						end
					end
					OP_FIRE: begin
						if (sts.known) begin
							cmd.i_sel = I_SLOT;
							cmd.n_sel = N_DEC;
							cmd.cnt_op = CNT_DEC;
							cmd.res_fv = 1'b1;
						end else begin
							cmd.res_status = STAT_UNKNOWN;
						end
					end
					OP_CLEAR: cmd.cnt_op = CNT_CLR;
					default: ;
				endcase
			end
			S_EXPCHK: begin
				cmd.res_ld = 1'b1;
				if (sts.root_due) begin
					cmd.i_sel = I_ZERO;
					cmd.n_sel = N_DEC;
					cmd.cnt_op = CNT_DEC;
					cmd.res_fv = 1'b1;
					cmd.fid_root = 1'b1;
				end
			end
			S_RDLAST: cmd.rd_sel = RD_LAST;
			S_LAST2: begin
				cmd.ld_e_rd = 1'b1;
				cmd.clr_moved = 1'b1;
			end
			S_DN1: cmd.rd_sel = RD_C1;
			S_DN2: begin
				cmd.ld_ch1 = 1'b1;
				cmd.rd_sel = RD_C2;
			end
			S_DN3:   cmd.ld_ch2 = 1'b1;
			S_DNCMP: cmd.mv_ch = !sts.e_lt_ch;
			S_UP:    cmd.rd_sel = RD_PAR;
			S_UPCMP: cmd.mv_par = !sts.par_lt_e;
			S_FIN:   cmd.wr_e = 1'b1;
			S_EXPEMIT: begin
				cmd.out_ld = sts.out_free;
				cmd.out_last = !sts.root_due;
			end
			S_EMIT: begin
				cmd.out_ld = sts.out_free;
				cmd.out_last = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/mhtq_dp.sv @@
// Timer queue datapath: heap and id-to-slot memories, sift registers, entry count,
// root copy and result register. Depends on mhtq_pkg; driven by mhtq_ctrl.
module mhtq_dp #(
	parameter int unsigned HEAP_CAPACITY = mhtq_pkg::HEAP_CAPACITY_DEF,
	parameter int unsigned ID_SPACE      = mhtq_pkg::ID_SPACE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mhtq_pkg::cmd_t               cmd,
	output mhtq_pkg::sts_t               sts,
	input  logic [mhtq_pkg::OP_W-1:0]    operation,
	input  logic [mhtq_pkg::ID_W-1:0]    timer_id,
	input  logic [mhtq_pkg::TMO_W-1:0]   timeout_ms,
	input  logic [mhtq_pkg::TIME_W-1:0]  now_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mhtq_pkg::STAT_W-1:0]  status,
	output logic                         fired_valid,
	output logic [mhtq_pkg::ID_W-1:0]    fired_id,
	output logic                         queue_empty,
	output logic [mhtq_pkg::TIME_W-1:0]  next_wait_ms,
	output logic                         last
);
	import mhtq_pkg::*;

	localparam int unsigned AW  = $clog2(HEAP_CAPACITY);
	localparam int unsigned CW  = $clog2(HEAP_CAPACITY + 1);
	localparam int unsigned IW  = $clog2(ID_SPACE);
	localparam int unsigned CHW = AW + 2;

	entry_t heap_mem [HEAP_CAPACITY];
	logic [AW-1:0] slot_mem [ID_SPACE];

	op_t               op_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] exp_q;
	logic [TIME_W-1:0] now_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     n_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     ch_idx_q;
	logic              moved_q;
	entry_t            e_q, ch_q, root_q, hrd_q;
	logic [AW-1:0]     slot_rd_q;
	logic [STAT_W-1:0] res_status_q;
	logic              res_fv_q;
	logic [ID_W-1:0]   res_fid_q;
	logic              out_valid_q;

	logic [TIME_W:0]   exp_sum;
	logic [CHW-1:0]    c1, c2;
	logic [AW-1:0]     par;
	logic [AW-1:0]     rd_addr;
	logic              hwr_en;
	entry_t            hwr_data;
	logic              out_free;
	logic [TIME_W-1:0] wait_ms;

	assign exp_sum = {1'b0, now_ms} + (TIME_W+1)'(timeout_ms);
	assign c1 = {1'b0, i_q, 1'b1};
	assign c2 = c1 + CHW'(1);
	assign par = AW'((i_q - AW'(1)) >> 1);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		case (cmd.rd_sel)
			RD_SLOT: rd_addr = slot_rd_q;
			RD_C1:   rd_addr = c1[AW-1:0];
			RD_C2:   rd_addr = c2[AW-1:0];
			RD_PAR:  rd_addr = par;
			RD_LAST: rd_addr = AW'(n_q);
			default: rd_addr = slot_rd_q;
		endcase
	end

	always_comb begin
		hwr_en = cmd.mv_ch || cmd.mv_par || cmd.wr_e;
		if (cmd.mv_ch) hwr_data = ch_q;
		else if (cmd.mv_par) hwr_data = hrd_q;
		else hwr_data = e_q;
	end

	always_ff @(posedge clk) begin
		hrd_q <= heap_mem[rd_addr];
		if (hwr_en) heap_mem[i_q] <= hwr_data;
	end

	always_ff @(posedge clk) begin
		slot_rd_q <= slot_mem[IW'(id_q)];
		if (hwr_en) slot_mem[IW'(hwr_data.owner)] <= i_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			op_q  <= op_t'(operation);
			id_q  <= timer_id;
			now_q <= now_ms;
			exp_q <= exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];
		end
		if (hwr_en && i_q == '0) root_q <= hwr_data;
		if (cmd.ld_e_in) e_q <= '{expiry: exp_q, owner: id_q};
		else if (cmd.ld_e_rd) e_q <= hrd_q;
		if (cmd.ld_ch1) begin
			ch_q <= hrd_q;
			ch_idx_q <= c1[AW-1:0];
		end else if (cmd.ld_ch2 && hrd_q.expiry < ch_q.expiry) begin
			ch_q <= hrd_q;
			ch_idx_q <= c2[AW-1:0];
		end
		case (cmd.i_sel)
			I_SLOT:  i_q <= slot_rd_q;
			I_COUNT: i_q <= AW'(count_q);
			I_ZERO:  i_q <= '0;
			default: begin
				if (cmd.mv_ch) i_q <= ch_idx_q;
				else if (cmd.mv_par) i_q <= par;
			end
		endcase
		case (cmd.n_sel)
			N_CNT:   n_q <= count_q;
			N_INC:   n_q <= count_q + CW'(1);
			N_DEC:   n_q <= count_q - CW'(1);
			default: n_q <= n_q;
		endcase
		if (cmd.res_ld) begin
			res_status_q <= cmd.res_status;
			res_fv_q <= cmd.res_fv;
			res_fid_q <= cmd.fid_root ? root_q.owner : id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			moved_q <= 1'b0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + CW'(1);
				CNT_DEC: count_q <= count_q - CW'(1);
				CNT_CLR: count_q <= '0;
				default: count_q <= count_q;
			endcase
			if (cmd.clr_moved) moved_q <= 1'b0;
			else if (cmd.mv_ch) moved_q <= 1'b1;
		end
	end

	assign wait_ms = (count_q != '0 && root_q.expiry > now_q) ? root_q.expiry - now_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			status       <= res_status_q;
			fired_valid  <= res_fv_q;
			fired_id     <= res_fv_q ? res_fid_q : '0;
			last         <= cmd.out_last;
			queue_empty  <= cmd.out_last && count_q == '0;
			next_wait_ms <= cmd.out_last ? wait_ms : '0;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.op       = op_q;
		sts.in_range = 32'(id_q) < 32'(ID_SPACE);
		sts.known    = sts.in_range && (CW'(slot_rd_q) < count_q) && (hrd_q.owner == id_q);
		sts.full     = count_q >= CW'(HEAP_CAPACITY);
		sts.c1_ok    = c1 < CHW'(n_q);
		sts.c2_ok    = c2 < CHW'(n_q);
		sts.i_zero   = i_q == '0;
		sts.e_lt_ch  = e_q.expiry < ch_q.expiry;
		sts.par_lt_e = hrd_q.expiry < e_q.expiry;
		sts.root_due = count_q != '0 && root_q.expiry <= now_q;
		sts.i_lt_n   = CW'(i_q) < n_q;
		sts.moved    = moved_q;
		sts.out_free = out_free;
	end

endmodule

@@ hw/rtl/min_heap_timer_queue.sv @@
// Binary min-heap timer queue, one transaction at a time.
// A lookup starts each transaction; one that changes the heap sifts down or up level by level,
// then writes back. The slowest case to the first result is an expire on a full heap.
// Expire pops again for each further fired timer; output stalls add more.
// Throughput: next transaction accepted the cycle after its last result is loaded.
// Reset clears the controller, entry count and output valid; memories need no clearing.
module min_heap_timer_queue #(
	parameter int unsigned HEAP_CAPACITY = mhtq_pkg::HEAP_CAPACITY_DEF,
	parameter int unsigned ID_SPACE      = mhtq_pkg::ID_SPACE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mhtq_pkg::OP_W-1:0]    operation,
	input  logic [mhtq_pkg::ID_W-1:0]    timer_id,
	input  logic [mhtq_pkg::TMO_W-1:0]   timeout_ms,
	input  logic [mhtq_pkg::TIME_W-1:0]  now_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mhtq_pkg::STAT_W-1:0]  status,
	output logic                         fired_valid,
	output logic [mhtq_pkg::ID_W-1:0]    fired_id,
	output logic                         queue_empty,
	output logic [mhtq_pkg::TIME_W-1:0]  next_wait_ms,
	output logic                         last
);
	import mhtq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mhtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mhtq_dp #(
		.HEAP_CAPACITY (HEAP_CAPACITY),
		.ID_SPACE      (ID_SPACE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.timer_id     (timer_id),
		.timeout_ms   (timeout_ms),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.fired_valid  (fired_valid),
		.fired_id     (fired_id),
		.queue_empty  (queue_empty),
		.next_wait_ms (next_wait_ms),
		.last         (last)
	);

endmodule
